// ===== sv/ahr_pkg.sv =====
// ahr_pkg: shared types, status codes and header constants for the A/B
// header recovery block. No dependencies.
package ahr_pkg;

    localparam int HEAD_BYTES_DEF = 24;
    // Checked header layout: bytes 0..23 are interpreted, the CRC covers 0..19
    localparam int FIELD_BYTES    = 24;
    localparam int CRC_BYTES      = 20;
    localparam int POS_SCHEMA     = 5;
    localparam int POS_FLAGS      = 7;
    localparam int POS_GEN        = 11;
    localparam int POS_LEN        = 15;
    localparam int POS_MCRC       = 19;
    localparam int POS_CHECK      = 23;
    localparam int MAGIC_LEN      = 4;

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] HALF_SPAN = 32'h8000_0000;
    // magic bytes, entry 0 is the first on the wire
    localparam logic [3:0][7:0] HEAD_MAGIC = {8'h48, 8'h48, 8'h53, 8'h4C};

    localparam logic [15:0] SCHEMA_RESET = 16'd1;

    // head status codes
    localparam logic [2:0] HS_VALID    = 3'd0;
    localparam logic [2:0] HS_SHORT    = 3'd1;
    localparam logic [2:0] HS_MAGIC    = 3'd2;
    localparam logic [2:0] HS_SCHEMA   = 3'd3;
    localparam logic [2:0] HS_FLAGS    = 3'd4;
    localparam logic [2:0] HS_CHECKSUM = 3'd5;

    // copy status codes
    localparam logic [2:0] CS_VALID       = 3'd0;
    localparam logic [2:0] CS_BAD_HEAD    = 3'd1;
    localparam logic [2:0] CS_NO_MANIFEST = 3'd2;
    localparam logic [2:0] CS_MISMATCH    = 3'd3;
    localparam logic [2:0] CS_BAD_PAYLOAD = 3'd4;

    // choice codes
    localparam logic [1:0] CH_NONE     = 2'd0;
    localparam logic [1:0] CH_A        = 2'd1;
    localparam logic [1:0] CH_B        = 2'd2;
    localparam logic [1:0] CH_CONFLICT = 2'd3;

    localparam logic SLOT_A = 1'b0;
    localparam logic SLOT_B = 1'b1;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic        slot;
        logic        last_byte;
        logic        manifest_present;
        logic [31:0] manifest_length;
        logic [31:0] manifest_crc;
        logic        payload_valid;
    } head_item_t;

    typedef struct packed {
        logic        result_slot;
        logic [2:0]  head_status;
        logic [2:0]  copy_status;
        logic        choice_ready;
        logic [1:0]  choice;
        logic [31:0] chosen_generation;
        logic [31:0] chosen_manifest_length;
        logic [31:0] chosen_manifest_crc;
    } res_item_t;

    // per-copy verdict handed from the checker to the slot selector
    typedef struct packed {
        logic [2:0]  head_status;
        logic [2:0]  copy_status;
        logic [31:0] generation;
        logic [31:0] manifest_length;
        logic [31:0] manifest_crc;
    } copy_sum_t;

endpackage

// ===== sv/ahr_copy_check.sv =====
// ahr_copy_check: per-copy byte walker with CRC-32C, magic/schema/flags
// checks and field capture. Depends on ahr_pkg.
module ahr_copy_check #(
    parameter int HEAD_BYTES = ahr_pkg::HEAD_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ahr_pkg::head_item_t item,
    input  logic [15:0]        schema,
    output ahr_pkg::copy_sum_t summary
);

    localparam int CW = $clog2(HEAD_BYTES + 1);
    localparam logic [CW-1:0] HB_LAST = CW'(HEAD_BYTES);

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
            r = (r >> 1) ^ (ahr_pkg::CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   crc_reg, crc_next;
    logic [2:0]    err_reg, err_next;
    logic [31:0]   shift_reg, shift_next;
    logic [31:0]   gen_reg, gen_next;
    logic [31:0]   len_reg, len_next;
    logic [31:0]   mcrc_reg, mcrc_next;
    logic [2:0]    code;
    logic [2:0]    hs;
    logic [2:0]    cs;

    always_comb
    begin
        shift_next = shift_reg;
        crc_next   = crc_reg;
        gen_next   = gen_reg;
        len_next   = len_reg;
        mcrc_next  = mcrc_reg;
        code       = ahr_pkg::HS_VALID;
        if (count_reg < CW'(ahr_pkg::FIELD_BYTES))
        begin
            shift_next = {shift_reg[23:0], item.head_byte};
            if (count_reg < CW'(ahr_pkg::CRC_BYTES))
                crc_next = crc_byte(crc_reg, item.head_byte);
            if (count_reg < CW'(ahr_pkg::MAGIC_LEN))
            begin
                if (item.head_byte != ahr_pkg::HEAD_MAGIC[count_reg[1:0]])
                    code = ahr_pkg::HS_MAGIC;
            end
            else if (count_reg == CW'(ahr_pkg::POS_SCHEMA))
            begin
                if (shift_next[15:0] != schema)
                    code = ahr_pkg::HS_SCHEMA;
            end
            else if (count_reg == CW'(ahr_pkg::POS_FLAGS))
            begin
                if (shift_next[15:0] != 16'h0)
                    code = ahr_pkg::HS_FLAGS;
            end
            else if (count_reg == CW'(ahr_pkg::POS_GEN))
                gen_next = shift_next;
            else if (count_reg == CW'(ahr_pkg::POS_LEN))
                len_next = shift_next;
            else if (count_reg == CW'(ahr_pkg::POS_MCRC))
                mcrc_next = shift_next;
            else if (count_reg == CW'(ahr_pkg::POS_CHECK))
            begin
                // the CRC stopped updating after byte 19
                if (shift_next != ~crc_reg)
                    code = ahr_pkg::HS_CHECKSUM;
            end
        end
        err_next   = (err_reg == ahr_pkg::HS_VALID) ? code : err_reg;
        count_next = (count_reg < HB_LAST) ? count_reg + CW'(1) : count_reg;

        // short copy outranks every other error
        hs = (count_next < HB_LAST) ? ahr_pkg::HS_SHORT : err_next;
        if (hs != ahr_pkg::HS_VALID)
            cs = ahr_pkg::CS_BAD_HEAD;
        else if (!item.manifest_present)
            cs = ahr_pkg::CS_NO_MANIFEST;
        else if (item.manifest_length != len_next || item.manifest_crc != mcrc_next)
            cs = ahr_pkg::CS_MISMATCH;
        else if (!item.payload_valid)
            cs = ahr_pkg::CS_BAD_PAYLOAD;
        else
            cs = ahr_pkg::CS_VALID;

        summary.head_status     = hs;
        summary.copy_status     = cs;
        summary.generation      = gen_next;
        summary.manifest_length = len_next;
        summary.manifest_crc    = mcrc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= ahr_pkg::CRC_INIT;
            err_reg   <= ahr_pkg::HS_VALID;
            shift_reg <= '0;
            gen_reg   <= '0;
            len_reg   <= '0;
            mcrc_reg  <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                count_reg <= '0;
                crc_reg   <= ahr_pkg::CRC_INIT;
                err_reg   <= ahr_pkg::HS_VALID;
                shift_reg <= '0;
                gen_reg   <= '0;
                len_reg   <= '0;
                mcrc_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                err_reg   <= err_next;
                shift_reg <= shift_next;
                gen_reg   <= gen_next;
                len_reg   <= len_next;
                mcrc_reg  <= mcrc_next;
            end
        end
    end

endmodule

// ===== sv/ahr_select.sv =====
// ahr_select: holds the slot A record and picks A, B, none or conflict on
// a slot B verdict. Depends on ahr_pkg.
module ahr_select (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               slot,
    input  ahr_pkg::copy_sum_t summary,
    output ahr_pkg::res_item_t result
);

    logic [2:0]  a_status_reg;
    logic [31:0] a_gen_reg;
    logic [31:0] a_len_reg;
    logic [31:0] a_mcrc_reg;
    logic        a_ok;
    logic        b_ok;
    logic [31:0] delta;
    logic [1:0]  choice;

    always_comb
    begin
        a_ok   = (a_status_reg == ahr_pkg::CS_VALID);
        b_ok   = (summary.copy_status == ahr_pkg::CS_VALID);
        delta  = a_gen_reg - summary.generation;
        choice = ahr_pkg::CH_NONE;
        if (slot == ahr_pkg::SLOT_B)
        begin
            if (a_ok && !b_ok)
                choice = ahr_pkg::CH_A;
            else if (!a_ok && b_ok)
                choice = ahr_pkg::CH_B;
            else if (a_ok && b_ok)
            begin
                if (delta == 32'h0)
                    choice = (a_len_reg != summary.manifest_length ||
                              a_mcrc_reg != summary.manifest_crc) ?
                             ahr_pkg::CH_CONFLICT : ahr_pkg::CH_A;
                else if (delta == ahr_pkg::HALF_SPAN)
                    choice = ahr_pkg::CH_CONFLICT;
                else if (!delta[31])
                    choice = ahr_pkg::CH_A;
                else
                    choice = ahr_pkg::CH_B;
            end
        end

        result.result_slot  = slot;
        result.head_status  = summary.head_status;
        result.copy_status  = summary.copy_status;
        result.choice_ready = slot;
        result.choice       = choice;
        result.chosen_generation      = '0;
        result.chosen_manifest_length = '0;
        result.chosen_manifest_crc    = '0;
        if (choice == ahr_pkg::CH_A)
        begin
            result.chosen_generation      = a_gen_reg;
            result.chosen_manifest_length = a_len_reg;
            result.chosen_manifest_crc    = a_mcrc_reg;
        end
        else if (choice == ahr_pkg::CH_B)
        begin
            result.chosen_generation      = summary.generation;
            result.chosen_manifest_length = summary.manifest_length;
            result.chosen_manifest_crc    = summary.manifest_crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_status_reg <= ahr_pkg::CS_BAD_HEAD;
            a_gen_reg    <= '0;
            a_len_reg    <= '0;
            a_mcrc_reg   <= '0;
        end
        else if (step)
        begin
            if (slot == ahr_pkg::SLOT_A)
            begin
                a_status_reg <= summary.copy_status;
                a_gen_reg    <= summary.generation;
                a_len_reg    <= summary.manifest_length;
                a_mcrc_reg   <= summary.manifest_crc;
            end
            else
            begin
                // B closes the pair; a later B stands alone
                a_status_reg <= ahr_pkg::CS_BAD_HEAD;
                a_gen_reg    <= '0;
                a_len_reg    <= '0;
                a_mcrc_reg   <= '0;
            end
        end
    end

endmodule

// ===== sv/ab_head_record_recovery_core.sv =====
// ab_head_record_recovery_core: top level, input register, result register
// and configuration. Depends on ahr_pkg, ahr_copy_check, ahr_select.
//
// Header bytes of slot A then slot B enter one item per clock while
// head_stall is low, with no gaps needed. Each accepted byte is held in
// the input register; from there the byte-wide CRC-32C update, field
// checks and, on a copy's last byte, the slot choice into the result
// register are done. The input keeps flowing while a result waits; only
// a last byte stalls, when the result register is still full and
// stalled. The schema register resets to 1 and must be written through
// cfg only while no item is in flight; the block does not enforce this.
// cfg_ready is always high.
module ab_head_record_recovery_core #(
    parameter int HEAD_BYTES = ahr_pkg::HEAD_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    output logic                head_stall,
    input  ahr_pkg::head_item_t head_item,
    output logic                res_valid,
    input  logic                res_stall,
    output ahr_pkg::res_item_t  res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic                s1_valid_reg;
    ahr_pkg::head_item_t s1_item_reg;
    logic                res_valid_reg;
    ahr_pkg::res_item_t  res_item_reg;
    logic [15:0]         schema_reg;
    logic                out_free;
    logic                s1_advance;
    ahr_pkg::copy_sum_t  summary;
    ahr_pkg::res_item_t  result;

    assign out_free   = !res_valid_reg || !res_stall;
    assign s1_advance = s1_valid_reg && (!s1_item_reg.last_byte || out_free);
    assign head_stall = s1_valid_reg && !s1_advance;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    ahr_copy_check #(
        .HEAD_BYTES(HEAD_BYTES)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance),
        .item    (s1_item_reg),
        .schema  (schema_reg),
        .summary (summary)
    );

    ahr_select u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance && s1_item_reg.last_byte),
        .slot    (s1_item_reg.slot),
        .summary (summary),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            schema_reg    <= ahr_pkg::SCHEMA_RESET;
        end
        else
        begin
            if (!head_stall)
                s1_valid_reg <= head_valid;
            if (s1_advance && s1_item_reg.last_byte)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                schema_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_valid && !head_stall)
            s1_item_reg <= head_item;
        if (s1_advance && s1_item_reg.last_byte)
            res_item_reg <= result;
    end

    // a held input item must not move while it waits for the result register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register changed while stalled");

    a_choice_only_b: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_item_reg.choice_ready == res_item_reg.result_slot &&
        (res_item_reg.result_slot == ahr_pkg::SLOT_B ||
         res_item_reg.choice == ahr_pkg::CH_NONE))
        else $error("choice given on a slot A result");

    a_bad_head: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.head_status != ahr_pkg::HS_VALID |->
        res_item_reg.copy_status == ahr_pkg::CS_BAD_HEAD)
        else $error("bad head not reflected in copy status");

    a_no_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_item_reg.choice == ahr_pkg::CH_NONE ||
                          res_item_reg.choice == ahr_pkg::CH_CONFLICT) |->
        res_item_reg.chosen_generation == 32'h0 &&
        res_item_reg.chosen_manifest_length == 32'h0 &&
        res_item_reg.chosen_manifest_crc == 32'h0)
        else $error("chosen fields set without a pick");

endmodule

// ===== test/ab_head_record_recovery_core_tb.sv =====
// Self-checking testbench for ab_head_record_recovery_core: streams A/B header copies,
// predicts head/copy status and the slot choice, and checks every result item.
// Depends on ahr_pkg and the core RTL.
module ab_head_record_recovery_core_tb;
    import ahr_pkg::*;

    typedef enum int {FT_NONE, FT_SHORT, FT_MAGIC, FT_SCHEMA, FT_FLAGS, FT_CHECKSUM,
                      FT_MULTI} fault_t;
    typedef enum int {MF_GOOD, MF_ABSENT, MF_LEN_DIFF, MF_CRC_DIFF, MF_PAY_BAD} manifest_case_t;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_START    = 1500;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        head_valid = 1'b0;
    logic        head_stall;
    head_item_t  head_item = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    ab_head_record_recovery_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_stall (head_stall),
        .head_item  (head_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pending header bytes and expected result items
    head_item_t byte_q[$];
    res_item_t  verdict_q[$];

    int fail_count   = 0;
    int queued_items = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int stall_clock  = 0;
    int quiet_cycles = 0;

    // predictor state
    logic [15:0] schema_exp;
    int          byte_pos;
    logic [31:0] crc_run;
    logic [2:0]  fault_code;
    logic [31:0] field_sr;
    logic [31:0] cur_gen, cur_len, cur_mcrc;
    logic [2:0]  held_status;
    logic [31:0] held_gen, held_len, held_mcrc;

    // stimulus side
    logic [15:0] cur_schema;
    logic [7:0]  hdr [0:63];
    logic [31:0] a_gen_sent, a_len_sent, a_crc_sent;

    function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] r;
        int k;
        r = acc ^ {24'd0, d};
        for (k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic clear_copy();
        byte_pos   = 0;
        crc_run    = CRC_INIT;
        fault_code = HS_VALID;
        field_sr   = '0;
        cur_gen    = '0;
        cur_len    = '0;
        cur_mcrc   = '0;
    endtask

    task automatic note_fault(input logic [2:0] code);
        if (fault_code == HS_VALID)
            fault_code = code;
    endtask

    // advance the copy checker by one header byte; queue a verdict on the last byte
    task automatic take_head_byte(input head_item_t it);
        res_item_t  r;
        logic [2:0] hs, cs;
        logic       a_ok, b_ok;
        logic [31:0] span;
        if (byte_pos < FIELD_BYTES)
        begin
            field_sr = {field_sr[23:0], it.head_byte};
            if (byte_pos < CRC_BYTES)
                crc_run = crc32c_step(crc_run, it.head_byte);
            if (byte_pos < MAGIC_LEN)
            begin
                if (it.head_byte != HEAD_MAGIC[byte_pos])
                    note_fault(HS_MAGIC);
            end
            else
            begin
                case (byte_pos)
                    POS_SCHEMA: if (field_sr[15:0] != schema_exp) note_fault(HS_SCHEMA);
                    POS_FLAGS:  if (field_sr[15:0] != 16'd0) note_fault(HS_FLAGS);
                    POS_GEN:    cur_gen = field_sr;
                    POS_LEN:    cur_len = field_sr;
                    POS_MCRC:   cur_mcrc = field_sr;
                    POS_CHECK:  if (field_sr != ~crc_run) note_fault(HS_CHECKSUM);
                    default:    ;
                endcase
            end
        end
        if (byte_pos < HEAD_BYTES_DEF)
            byte_pos++;
        if (!it.last_byte)
            return;

        hs = (byte_pos < HEAD_BYTES_DEF) ? HS_SHORT : fault_code;
        if (hs != HS_VALID)
            cs = CS_BAD_HEAD;
        else if (!it.manifest_present)
            cs = CS_NO_MANIFEST;
        else if (it.manifest_length != cur_len || it.manifest_crc != cur_mcrc)
            cs = CS_MISMATCH;
        else if (!it.payload_valid)
            cs = CS_BAD_PAYLOAD;
        else
            cs = CS_VALID;

        r = '0;
        r.result_slot  = it.slot;
        r.head_status  = hs;
        r.copy_status  = cs;
        r.choice_ready = it.slot;
        if (it.slot == SLOT_A)
        begin
            held_status = cs;
            held_gen    = cur_gen;
            held_len    = cur_len;
            held_mcrc   = cur_mcrc;
        end
        else
        begin
            a_ok = (held_status == CS_VALID);
            b_ok = (cs == CS_VALID);
            r.choice = CH_NONE;
            if (a_ok && !b_ok)
                r.choice = CH_A;
            else if (!a_ok && b_ok)
                r.choice = CH_B;
            else if (a_ok && b_ok)
            begin
                if (held_gen == cur_gen)
                    r.choice = (held_len != cur_len || held_mcrc != cur_mcrc) ? CH_CONFLICT : CH_A;
                else
                begin
                    // serial-number compare: A is newer when A - B lies in the lower half
                    span = held_gen - cur_gen;
                    if (span == HALF_SPAN)
                        r.choice = CH_CONFLICT;
                    else if (span < HALF_SPAN)
                        r.choice = CH_A;
                    else
                        r.choice = CH_B;
                end
            end
            if (r.choice == CH_A)
            begin
                r.chosen_generation      = held_gen;
                r.chosen_manifest_length = held_len;
                r.chosen_manifest_crc    = held_mcrc;
            end
            else if (r.choice == CH_B)
            begin
                r.chosen_generation      = cur_gen;
                r.chosen_manifest_length = cur_len;
                r.chosen_manifest_crc    = cur_mcrc;
            end
            held_status = CS_BAD_HEAD;
            held_gen    = '0;
            held_len    = '0;
            held_mcrc   = '0;
        end
        verdict_q.push_back(r);
        clear_copy();
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fail_count++;
        end
    endtask

    // queue hdr[0..nb-1] as one copy; manifest facts ride on the last byte
    task automatic push_copy(input logic s, input int nb, input manifest_case_t m);
        head_item_t it;
        int i;
        for (i = 0; i < nb; i++)
        begin
            it.head_byte        = hdr[i];
            it.last_byte        = (i == nb - 1);
            it.slot             = it.last_byte ? s : 1'($urandom_range(0, 1));
            it.manifest_present = 1'($urandom_range(0, 1));
            it.manifest_length  = $urandom;
            it.manifest_crc     = $urandom;
            it.payload_valid    = 1'($urandom_range(0, 1));
            if (it.last_byte)
            begin
                it.manifest_present = (m != MF_ABSENT);
                it.manifest_length  = {hdr[12], hdr[13], hdr[14], hdr[15]};
                it.manifest_crc     = {hdr[16], hdr[17], hdr[18], hdr[19]};
                it.payload_valid    = (m != MF_PAY_BAD);
                if (m == MF_LEN_DIFF)
                    it.manifest_length ^= 32'd1 << $urandom_range(0, 31);
                if (m == MF_CRC_DIFF)
                    it.manifest_crc ^= 32'd1 << $urandom_range(0, 31);
            end
            byte_q.push_back(it);
        end
        queued_items += nb;
    endtask

    task automatic send_copy(input logic s, input logic [31:0] g, input logic [31:0] l,
                             input logic [31:0] c, input fault_t f, input manifest_case_t m,
                             input int nb);
        logic [15:0] ver, flg;
        logic [31:0] sum;
        int i, k;
        ver = cur_schema;
        flg = '0;
        if (f == FT_SCHEMA || f == FT_MULTI)
            ver = cur_schema ^ 16'($urandom_range(1, 16'hFFFF));
        if (f == FT_FLAGS || f == FT_MULTI)
            flg = 16'($urandom_range(1, 16'hFFFF));
        for (i = 0; i < 64; i++)
            hdr[i] = 8'($urandom);
        for (i = 0; i < MAGIC_LEN; i++)
            hdr[i] = HEAD_MAGIC[i];
        {hdr[4], hdr[5]} = ver;
        {hdr[6], hdr[7]} = flg;
        {hdr[8], hdr[9], hdr[10], hdr[11]}  = g;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = l;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = c;
        sum = CRC_INIT;
        for (i = 0; i < CRC_BYTES; i++)
            sum = crc32c_step(sum, hdr[i]);
        {hdr[20], hdr[21], hdr[22], hdr[23]} = ~sum;
        if (f == FT_MAGIC || (f == FT_MULTI && $urandom_range(0, 1) == 1))
        begin
            k = $urandom_range(0, MAGIC_LEN - 1);
            hdr[k] ^= 8'($urandom_range(1, 255));
        end
        if (f == FT_CHECKSUM || f == FT_MULTI)
        begin
            k = $urandom_range(8, POS_CHECK);
            hdr[k] ^= 8'd1 << $urandom_range(0, 7);
        end
        if (f == FT_SHORT && nb >= FIELD_BYTES)
            nb = $urandom_range(1, FIELD_BYTES - 1);
        push_copy(s, nb, m);
    endtask

    task automatic rand_copy(input logic s);
        logic [31:0] g, l, c;
        fault_t f;
        manifest_case_t m;
        int r, nb;
        l = rand_word();
        c = rand_word();
        if (s == SLOT_A)
        begin
            g = rand_word();
            a_gen_sent = g;
            a_len_sent = l;
            a_crc_sent = c;
        end
        else
        begin
            // mostly place B's generation near the last A, or half the range away, so the serial compare gets exercised
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                g = a_gen_sent;
                if (r < 10)
                begin
                    l = a_len_sent;
                    c = a_crc_sent;
                end
            end
            else if (r < 45)
                g = a_gen_sent + $urandom_range(1, 5);
            else if (r < 70)
                g = a_gen_sent - $urandom_range(1, 5);
            else if (r < 78)
                g = a_gen_sent + HALF_SPAN;
            else if (r < 84)
                g = a_gen_sent + HALF_SPAN + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            else
                g = rand_word();
        end
        r = $urandom_range(0, 99);
        if (r < 80)
            f = FT_NONE;
        else if (r < 84)
            f = FT_SHORT;
        else if (r < 88)
            f = FT_MAGIC;
        else if (r < 91)
            f = FT_SCHEMA;
        else if (r < 94)
            f = FT_FLAGS;
        else if (r < 98)
            f = FT_CHECKSUM;
        else
            f = FT_MULTI;
        m = ($urandom_range(0, 9) < 8) ? MF_GOOD : manifest_case_t'($urandom_range(1, 4));
        nb = ($urandom_range(0, 99) < 85) ? FIELD_BYTES : $urandom_range(25, 40);
        send_copy(s, g, l, c, f, m, nb);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || head_valid || verdict_q.size() != 0);
        // a trailing byte without last_byte yields nothing; let it clear the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_schema(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        schema_exp = v;
        cur_schema = v;
        @(negedge clk);
    endtask

    task automatic run_random(input int n);
        int start, r, k, nb;
        start = queued_items;
        while (queued_items - start < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                rand_copy(SLOT_A);
                rand_copy(SLOT_B);
            end
            else if (r < 83)
                rand_copy(SLOT_B);
            else if (r < 90)
            begin
                rand_copy(SLOT_A);
                rand_copy(SLOT_A);
                rand_copy(SLOT_B);
            end
            else
            begin
                // raw noise copy
                nb = $urandom_range(1, 30);
                for (k = 0; k < 64; k++)
                    hdr[k] = 8'($urandom);
                push_copy(1'($urandom_range(0, 1)), nb,
                          manifest_case_t'($urandom_range(0, 4)));
            end
        end
        drain();
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (head_valid && !head_stall)
                take_head_byte(head_item);
            if (!head_valid || !head_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    head_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    head_item  <= byte_q.pop_front();
                    head_valid <= 1'b1;
                    send_gap = gap_len();
                end
                else
                    head_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold to back the block up
    always @(posedge clk)
    begin
        stall_clock++;
        if (stall_clock == HOLD_START)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin : result_check
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result item with no expectation pending");
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("result_slot", 32'(want.result_slot),
                            32'(res_item.result_slot));
                check_field("head_status", 32'(want.head_status),
                            32'(res_item.head_status));
                check_field("copy_status", 32'(want.copy_status),
                            32'(res_item.copy_status));
                check_field("choice_ready", 32'(want.choice_ready),
                            32'(res_item.choice_ready));
                check_field("choice", 32'(want.choice), 32'(res_item.choice));
                check_field("chosen_generation", want.chosen_generation,
                            res_item.chosen_generation);
                check_field("chosen_manifest_length", want.chosen_manifest_length,
                            res_item.chosen_manifest_length);
                check_field("chosen_manifest_crc", want.chosen_manifest_crc,
                            res_item.chosen_manifest_crc);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((head_valid && !head_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        schema_exp  = SCHEMA_RESET;
        cur_schema  = SCHEMA_RESET;
        clear_copy();
        held_status = CS_BAD_HEAD;
        held_gen    = '0;
        held_len    = '0;
        held_mcrc   = '0;
        a_gen_sent  = '0;
        a_len_sent  = '0;
        a_crc_sent  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // B judged alone after reset
        send_copy(SLOT_B, 32'h10, 32'h20, 32'h30, FT_NONE, MF_GOOD, 24);
        // field extremes; B is one behind A across the wrap, then one ahead
        send_copy(SLOT_A, 32'h0, 32'h0, 32'h0, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_A, 32'hFFFF_FFFF, 32'h1, 32'h2, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'h0, 32'h3, 32'h4, FT_NONE, MF_GOOD, 24);
        // equal generations: agree, then disagree
        send_copy(SLOT_A, 32'd7, 32'd100, 32'd200, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd7, 32'd100, 32'd200, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_A, 32'd7, 32'd100, 32'd200, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd7, 32'd101, 32'd200, FT_NONE, MF_GOOD, 24);
        // exactly half the range apart
        send_copy(SLOT_A, 32'd0, 32'd5, 32'd6, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, HALF_SPAN, 32'd5, 32'd6, FT_NONE, MF_GOOD, 24);
        // second A replaces the first; B has a bad checksum
        send_copy(SLOT_A, 32'd1, 32'd11, 32'd12, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_A, 32'd9, 32'd13, 32'd14, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd3, 32'd15, 32'd16, FT_CHECKSUM, MF_GOOD, 24);
        // short copies at both ends of the range
        send_copy(SLOT_A, 32'd1, 32'd2, 32'd3, FT_SHORT, MF_GOOD, 1);
        send_copy(SLOT_B, 32'd1, 32'd2, 32'd3, FT_SHORT, MF_GOOD, 23);
        // header errors, several at once first
        send_copy(SLOT_A, 32'd4, 32'd5, 32'd6, FT_MULTI, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd4, 32'd5, 32'd6, FT_FLAGS, MF_GOOD, 24);
        send_copy(SLOT_A, 32'd4, 32'd5, 32'd6, FT_SCHEMA, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd4, 32'd5, 32'd6, FT_MAGIC, MF_GOOD, 24);
        // long A wins over B with no manifest
        send_copy(SLOT_A, 32'd20, 32'd21, 32'd22, FT_NONE, MF_GOOD, 40);
        send_copy(SLOT_B, 32'd30, 32'd31, 32'd32, FT_NONE, MF_ABSENT, 24);
        // manifest and payload failures
        send_copy(SLOT_A, 32'd40, 32'd41, 32'd42, FT_NONE, MF_LEN_DIFF, 24);
        send_copy(SLOT_B, 32'd43, 32'd44, 32'd45, FT_NONE, MF_PAY_BAD, 24);
        send_copy(SLOT_A, 32'd50, 32'd51, 32'd52, FT_NONE, MF_CRC_DIFF, 24);
        send_copy(SLOT_B, 32'd60, 32'd61, 32'd62, FT_NONE, MF_GOOD, 24);
        // newer B wins
        send_copy(SLOT_A, 32'd100, 32'd1, 32'd2, FT_NONE, MF_GOOD, 24);
        send_copy(SLOT_B, 32'd200, 32'd3, 32'd4, FT_NONE, MF_GOOD, 24);
        drain();

        write_schema(16'hFFFF);
        run_random(250);
        write_schema(16'h0000);
        run_random(250);
        write_schema(16'($urandom));
        run_random(250);
        write_schema(SCHEMA_RESET);
        run_random(250);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ahr_pkg.sv
sv/ahr_copy_check.sv
sv/ahr_select.sv
sv/ab_head_record_recovery_core.sv
test/ab_head_record_recovery_core_tb.sv
